@@ src/stla_pkg.sv @@
`timescale 1ns / 1ps

package stla_pkg;

	// field widths
	localparam int WORD_W   = 31;
	localparam int FREQ_W   = 31;
	localparam int SC_W     = 7;
	localparam int LF_W     = 8;
	localparam int TOPIC_W  = 31;
	localparam int HOT_W    = 31;
	localparam int SHARD_W  = 6;
	localparam int SLOT_W   = 20;
	localparam int CAP_W    = 31;
	localparam int OFS_W    = 48;
	localparam int FSUM_W   = 48;

	// sparse bound = capacity multiplier * term_freq, power-of-two capacity up to 2^39
	localparam int BOUND_W  = LF_W + FREQ_W;
	localparam int POW_W    = BOUND_W + 1;

	// restoring modulo, one id bit per step
	localparam int DIV_STEPS = WORD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_SHARD_COUNT   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CAP_MULT      = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOPIC_COUNT   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOT_THRESHOLD = 4'd3;

	localparam logic [SC_W-1:0]    RST_SHARD_COUNT   = 7'd8;
	localparam logic [LF_W-1:0]    RST_CAP_MULT      = 8'd2;
	localparam logic [TOPIC_W-1:0] RST_TOPIC_COUNT   = 31'd1000000;
	localparam logic [HOT_W-1:0]   RST_HOT_THRESHOLD = 31'd250000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ITER,
		ST_READ,
		ST_OFS,
		ST_SUM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic mod_busy;
		logic pow_done;
	} iter_status_t;

endpackage

@@ src/stla_iter.sv @@
`timescale 1ns / 1ps

// Shared step unit: one restoring-modulo bit and one power-of-two step per cycle.
module stla_iter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [stla_pkg::WORD_W-1:0]       word,
	input  logic [stla_pkg::SC_W-1:0]         divisor,
	input  logic [stla_pkg::BOUND_W-1:0]      bound,
	output stla_pkg::iter_status_t            status,
	output logic [stla_pkg::SC_W-1:0]         rem,
	output logic [stla_pkg::POW_W-1:0]        cap
);

	localparam int WW = stla_pkg::WORD_W;
	localparam int NW = stla_pkg::SC_W;
	localparam int PW = stla_pkg::POW_W;
	localparam int XW = PW + 2;

	logic [WW-1:0]                 word_sh_q;
	logic [NW-1:0]                 rem_q;
	logic [stla_pkg::STEP_W-1:0]   cnt_q;
	logic                          mod_busy_q;
	logic [PW-1:0]                 cap_q;
	logic                          pow_done_q;

	logic [NW:0]   trial;
	logic [NW:0]   diff;
	logic [NW-1:0] rem_step;
	logic [XW-1:0] c0, c1, c2, bnd;

	always_comb begin
		trial    = {rem_q, word_sh_q[WW-1]};
		diff     = trial - {1'b0, divisor};
		rem_step = (trial >= {1'b0, divisor}) ? diff[NW-1:0] : trial[NW-1:0];
		c0       = {2'b00, cap_q};
		c1       = {1'b0, cap_q, 1'b0};
		c2       = {cap_q, 2'b00};
		bnd      = {{(XW-stla_pkg::BOUND_W){1'b0}}, bound};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_busy_q <= 1'b0;
			cnt_q      <= '0;
			pow_done_q <= 1'b1;
		end else if (start) begin
			mod_busy_q <= 1'b1;
			cnt_q      <= stla_pkg::STEP_W'(stla_pkg::DIV_STEPS - 1);
			pow_done_q <= 1'b0;
		end else begin
			if (mod_busy_q) begin
				if (cnt_q == '0) begin
					mod_busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			if (!pow_done_q && (c0 >= bnd)) begin
				pow_done_q <= 1'b1;
			end
		end
	end

	// doubles or quadruples; at most 20 steps, well inside the modulo pass
	always_ff @(posedge clk) begin
		if (start) begin
			word_sh_q <= word;
			rem_q     <= '0;
			cap_q     <= PW'(1);
		end else begin
			if (mod_busy_q) begin
				rem_q     <= rem_step;
				word_sh_q <= {word_sh_q[WW-2:0], 1'b0};
			end
			if (!pow_done_q && (c0 < bnd)) begin
				if (c1 >= bnd) begin
					cap_q <= c1[PW-1:0];
				end else begin
					cap_q <= c2[PW-1:0];
				end
			end
		end
	end

	assign status.mod_busy = mod_busy_q;
	assign status.pow_done = pow_done_q;
	assign rem             = rem_q;
	assign cap             = cap_q;

endmodule

@@ src/stla_shard_mem.sv @@
`timescale 1ns / 1ps

// Per-shard state store. Valid bits stand for the cleared state after reset.
module stla_shard_mem #(
	parameter int DEPTH   = 64,
	parameter int ADDR_W  = 6,
	parameter int ENTRY_W = 117
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	output logic [ENTRY_W-1:0] rd_data,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  logic [ENTRY_W-1:0] wr_data
);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   valid_q;
	logic [ENTRY_W-1:0] rd_data_q;
	logic               rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

@@ src/sharded_table_layout_allocator.sv @@
`timescale 1ns / 1ps

// Sharded table layout allocator.
// Input channel (in_valid / in_stall) carries one request: word_number and
// term_freq. Output channel (out_valid / out_stall) returns one result per
// request: shard, entry_slot, dense_row, row_capacity, start/end offsets,
// the shard's running frequency total and an overflow flag.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data); the user
// must see that it is written only while the block is idle, as the block itself
// does not enforce this; unknown indexes are ignored.
// Steps: after acceptance the capacity-multiplier product is formed, then the
// shared step unit runs (31 restoring-modulo steps of the id by the shard count,
// one bit a cycle, then its finish is seen; the power-of-two capacity search
// runs alongside and ends sooner), then come one shard-store read, the
// saturating offset update, the saturating total update and one output load.
// in_stall is high from acceptance until the output load and the next request
// is taken in the idle cycle after it, so a request is never taken before the
// last is done. A stalled result holds and blocks only the next output load.
// Reset: configuration returns to 8 / 2 / 1000000 / 250000 and all shard
// counters read as zero at once through per-shard valid bits; no sweep.
module sharded_table_layout_allocator #(
	parameter int MAX_SHARDS  = 64,
	parameter int MAX_ENTRIES = 1048576,
	parameter int OFFSET_BITS = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                cfg_write,
	input  logic [stla_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [stla_pkg::CFG_DATA_W-1:0]     cfg_data,

	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [stla_pkg::WORD_W-1:0]         word_number,
	input  logic [stla_pkg::FREQ_W-1:0]         term_freq,

	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [stla_pkg::SHARD_W-1:0]        shard,
	output logic [stla_pkg::SLOT_W-1:0]         entry_slot,
	output logic                                dense_row,
	output logic [stla_pkg::CAP_W-1:0]          row_capacity,
	output logic [stla_pkg::OFS_W-1:0]          start_offset,
	output logic [stla_pkg::OFS_W-1:0]          end_offset,
	output logic [stla_pkg::FSUM_W-1:0]         shard_freq_total,
	output logic                                overflow
);

	localparam int SIDX_W  = (MAX_SHARDS > 1) ? $clog2(MAX_SHARDS) : 1;
	localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
	localparam int SIZE_W  = stla_pkg::POW_W + 1;
	localparam int ADD_W   = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 1;
	localparam int FSUM_W  = stla_pkg::FSUM_W;
	localparam int ENTRY_W = CNT_W + OFFSET_BITS + FSUM_W;

	// configuration
	logic [stla_pkg::SC_W-1:0]    shard_count_q;
	logic [stla_pkg::LF_W-1:0]    cap_mult_q;
	logic [stla_pkg::TOPIC_W-1:0] topic_count_q;
	logic [stla_pkg::HOT_W-1:0]   hot_threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shard_count_q   <= stla_pkg::RST_SHARD_COUNT;
			cap_mult_q      <= stla_pkg::RST_CAP_MULT;
			topic_count_q   <= stla_pkg::RST_TOPIC_COUNT;
			hot_threshold_q <= stla_pkg::RST_HOT_THRESHOLD;
		end else if (cfg_write) begin
			case (cfg_index)
				stla_pkg::CFG_SHARD_COUNT:   shard_count_q   <= cfg_data[stla_pkg::SC_W-1:0];
				stla_pkg::CFG_CAP_MULT:      cap_mult_q      <= cfg_data[stla_pkg::LF_W-1:0];
				stla_pkg::CFG_TOPIC_COUNT:   topic_count_q   <= cfg_data;
				stla_pkg::CFG_HOT_THRESHOLD: hot_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective shard count: zero means one, clamp to the store depth
	logic [stla_pkg::SC_W-1:0] n_raw, n_eff;

	always_comb begin
		n_raw = (shard_count_q == '0) ? stla_pkg::SC_W'(1) : shard_count_q;
		n_eff = (32'(n_raw) > 32'(MAX_SHARDS)) ? stla_pkg::SC_W'(MAX_SHARDS) : n_raw;
	end

	// sequencer
	stla_pkg::state_t state_q, state_d;
	stla_pkg::iter_status_t iter_st;
	logic iter_start, iter_done;
	logic mem_rd_en, mem_wr_en, out_load;
	logic out_valid_q;

	assign iter_done = !iter_st.mod_busy && iter_st.pow_done;

	always_comb begin
		state_d = state_q;
		case (state_q)
			stla_pkg::ST_IDLE: if (in_valid) state_d = stla_pkg::ST_MUL;
			stla_pkg::ST_MUL:  state_d = stla_pkg::ST_ITER;
			stla_pkg::ST_ITER: if (iter_done) state_d = stla_pkg::ST_READ;
			stla_pkg::ST_READ: state_d = stla_pkg::ST_OFS;
			stla_pkg::ST_OFS:  state_d = stla_pkg::ST_SUM;
			stla_pkg::ST_SUM:  state_d = stla_pkg::ST_DONE;
			stla_pkg::ST_DONE: if (!out_valid_q || !out_stall) state_d = stla_pkg::ST_IDLE;
			default:           state_d = stla_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != stla_pkg::ST_IDLE);
		iter_start = (state_q == stla_pkg::ST_MUL);
		mem_rd_en  = (state_q == stla_pkg::ST_READ);
		mem_wr_en  = (state_q == stla_pkg::ST_SUM);
		out_load   = (state_q == stla_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stla_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture and product
	logic [stla_pkg::WORD_W-1:0]  word_q;
	logic [stla_pkg::FREQ_W-1:0]  tf_q;
	logic [stla_pkg::BOUND_W-1:0] bound_q;
	logic                         dense_q;

	always_ff @(posedge clk) begin
		if (state_q == stla_pkg::ST_IDLE && in_valid) begin
			word_q <= word_number;
			tf_q   <= term_freq;
		end
		if (state_q == stla_pkg::ST_MUL) begin
			bound_q <= stla_pkg::BOUND_W'(cap_mult_q) * stla_pkg::BOUND_W'(tf_q);
			dense_q <= (tf_q >= hot_threshold_q);
		end
	end

	// shared step unit
	logic [stla_pkg::SC_W-1:0]  rem;
	logic [stla_pkg::POW_W-1:0] pow_cap;

	stla_iter u_iter (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (iter_start),
		.word    (word_q),
		.divisor (n_eff),
		.bound   (bound_q),
		.status  (iter_st),
		.rem     (rem),
		.cap     (pow_cap)
	);

	// shard store
	logic [SIDX_W-1:0]  sidx;
	logic [ENTRY_W-1:0] rd_entry, wr_entry;

	assign sidx = SIDX_W'(rem);

	stla_shard_mem #(
		.DEPTH   (MAX_SHARDS),
		.ADDR_W  (SIDX_W),
		.ENTRY_W (ENTRY_W)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (sidx),
		.rd_data (rd_entry),
		.wr_en   (mem_wr_en),
		.wr_addr (sidx),
		.wr_data (wr_entry)
	);

	logic [CNT_W-1:0]       cnt_rd;
	logic [OFFSET_BITS-1:0] ofs_rd;
	logic [FSUM_W-1:0]      fsum_rd;

	assign cnt_rd  = rd_entry[ENTRY_W-1 -: CNT_W];
	assign ofs_rd  = rd_entry[FSUM_W+OFFSET_BITS-1 -: OFFSET_BITS];
	assign fsum_rd = rd_entry[FSUM_W-1:0];

	// offset step: capacity, slot, end offset
	logic [SIZE_W-1:0]      row_size;
	logic [ADD_W-1:0]       end_full;
	logic                   cap_sat, slot_full, end_sat;

	always_comb begin
		row_size  = dense_q ? SIZE_W'(topic_count_q) : {pow_cap, 1'b0};
		end_full  = ADD_W'(ofs_rd) + ADD_W'(row_size);
		end_sat   = |end_full[ADD_W-1:OFFSET_BITS];
		cap_sat   = !dense_q && (|pow_cap[stla_pkg::POW_W-1:stla_pkg::CAP_W]);
		slot_full = (cnt_rd >= CNT_W'(MAX_ENTRIES));
	end

	logic [CNT_W-1:0]         slot_q, cnt_new_q;
	logic [OFFSET_BITS-1:0]   start_q, end_q;
	logic [stla_pkg::CAP_W-1:0] cap_q;
	logic                     ovf_q;
	logic [FSUM_W-1:0]        fsum_old_q, fsum_q;

	// frequency total step: 49-bit add, saturate on carry out
	logic [FSUM_W:0] fsum_full;
	logic [FSUM_W-1:0] fsum_new;

	always_comb begin
		fsum_full = {1'b0, fsum_old_q} + (FSUM_W + 1)'(tf_q);
		fsum_new  = fsum_full[FSUM_W] ? '1 : fsum_full[FSUM_W-1:0];
		wr_entry  = {cnt_new_q, end_q, fsum_new};
	end

	always_ff @(posedge clk) begin
		if (state_q == stla_pkg::ST_OFS) begin
			if (slot_full) begin
				slot_q    <= CNT_W'(MAX_ENTRIES - 1);
				cnt_new_q <= cnt_rd;
			end else begin
				slot_q    <= cnt_rd;
				cnt_new_q <= cnt_rd + 1'b1;
			end
			start_q    <= ofs_rd;
			end_q      <= end_sat ? '1 : end_full[OFFSET_BITS-1:0];
			cap_q      <= dense_q ? topic_count_q :
			              (cap_sat ? '1 : pow_cap[stla_pkg::CAP_W-1:0]);
			ovf_q      <= slot_full || end_sat || cap_sat;
			fsum_old_q <= fsum_rd;
		end
		if (state_q == stla_pkg::ST_SUM) begin
			fsum_q <= fsum_new;
			ovf_q  <= ovf_q || fsum_full[FSUM_W];
		end
	end

	// output register
	logic [stla_pkg::SHARD_W-1:0] shard_q;
	logic [stla_pkg::SLOT_W-1:0]  entry_slot_q;
	logic                         dense_row_q;
	logic [stla_pkg::CAP_W-1:0]   row_capacity_q;
	logic [stla_pkg::OFS_W-1:0]   start_offset_q, end_offset_q;
	logic [FSUM_W-1:0]            shard_freq_total_q;
	logic                         overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			shard_q            <= stla_pkg::SHARD_W'(rem);
			entry_slot_q       <= stla_pkg::SLOT_W'(slot_q);
			dense_row_q        <= dense_q;
			row_capacity_q     <= cap_q;
			start_offset_q     <= stla_pkg::OFS_W'(start_q);
			end_offset_q       <= stla_pkg::OFS_W'(end_q);
			shard_freq_total_q <= fsum_q;
			overflow_q         <= ovf_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign shard            = shard_q;
	assign entry_slot       = entry_slot_q;
	assign dense_row        = dense_row_q;
	assign row_capacity     = row_capacity_q;
	assign start_offset     = start_offset_q;
	assign end_offset       = end_offset_q;
	assign shard_freq_total = shard_freq_total_q;
	assign overflow         = overflow_q;

endmodule
